/* rtl/vcsd_pkg.sv */
// ----------------------------------------------------------------------------
// vcsd_pkg
// Shared types, identifier codes and constants for the CAN signal decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package vcsd_pkg;

    // identifiers, compared as whole 32-bit words
    localparam logic [31:0] ID_GEAR  = 32'h0000_0300;
    localparam logic [31:0] ID_SPEED = 32'h0000_0302;
    localparam logic [31:0] ID_STEER = 32'h0000_0307;
    localparam logic [31:0] ID_TURN  = 32'h0000_0309;

    // operation kinds handed from front to back
    localparam logic [2:0] OP_OTHER = 3'd0;
    localparam logic [2:0] OP_GEAR  = 3'd1;
    localparam logic [2:0] OP_SPEED = 3'd2;
    localparam logic [2:0] OP_STEER = 3'd3;
    localparam logic [2:0] OP_TURN  = 3'd4;

    // mapped gear states
    localparam logic [2:0] GEAR_PARK    = 3'd0;
    localparam logic [2:0] GEAR_NEUTRAL = 3'd1;
    localparam logic [2:0] GEAR_DRIVE   = 3'd2;
    localparam logic [2:0] GEAR_REVERSE = 3'd3;
    localparam logic [2:0] GEAR_FAIL    = 3'd4;

    // raw gear codes on the bus
    localparam logic [2:0] GCODE_PARK    = 3'd0;
    localparam logic [2:0] GCODE_NEUTRAL = 3'd4;
    localparam logic [2:0] GCODE_DRIVE   = 3'd5;
    localparam logic [2:0] GCODE_REVERSE = 3'd7;

    // odometer: inc = floor(((prev + raw) * dt * 19 >> 7) / 9)
    localparam logic [17:0] ODO_GAIN = 18'd19;
    localparam int          ODO_SHR  = 7;
    localparam logic [5:0]  DIV_ODO  = 6'd9;
    localparam logic [47:0] ODO_MAX  = 48'hFFFF_FFFF_FFFF;

    // steer: floor((raw - 9000) * 256 / 180) = floor(raw * 64 / 45) - 12800
    localparam logic [5:0]  DIV_STEER  = 6'd45;
    localparam logic [17:0] STEER_OFFS = 18'd12800;

    // radix-16 constant divider
    localparam int DIV_NUM_W  = 44;
    localparam int DIV_DIGITS = DIV_NUM_W / 4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] arg;
        logic [31:0] ts;
    } t_op;

    typedef struct packed {
        logic [47:0]        odometer_um;
        logic signed [17:0] steer_q8;
        logic [11:0]        speed_eighths;
        logic [1:0]         turn_state;
        logic [2:0]         gear_state;
    } t_status;

    function automatic logic [2:0] f_map_gear(input logic [2:0] code);
        logic [2:0] res;
        unique case (code)
            GCODE_PARK:    res = GEAR_PARK;
            GCODE_NEUTRAL: res = GEAR_NEUTRAL;
            GCODE_DRIVE:   res = GEAR_DRIVE;
            GCODE_REVERSE: res = GEAR_REVERSE;
            default:       res = GEAR_FAIL;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/vehicle_can_signal_decoder.sv */
// ----------------------------------------------------------------------------
// vehicle_can_signal_decoder
// Decodes gear, speed, steer and turn frames and integrates the odometer.
// ----------------------------------------------------------------------------
//
//   channel   dir  beat contents
//   s_axis    in   one received frame: id, payload, timestamp
//   m_axis    out  one status beat per frame
//
// gear, turn and unknown frames go straight to emit in the back end; steer
// frames pass the radix-16 constant divider (11 digit steps), speed frames
// multiply, divide and accumulate, and a two-entry queue buffers new frames.
// reset is synchronous, active low, and clears all signals and the odometer.
// either side may stall freely; the status register holds until taken.
`default_nettype none

module vehicle_can_signal_decoder (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // frame_id[31:0], frame_data[95:32], timestamp_us[127:96]
    input  wire logic [127:0]  s_axis_tdata,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // gear_state[2:0], turn_state[4:3], speed_eighths[16:5],
    // steer_q8[34:17], odometer_um[82:35], zero fill [87:83]
    output logic [87:0]        m_axis_tdata
);
    import vcsd_pkg::*;

    logic    w_op_valid;
    t_op     w_op;
    logic    w_op_pop;
    t_status w_res;

    vcsd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_frame_id     (s_axis_tdata[31:0]),
        .i_frame_data   (s_axis_tdata[95:32]),
        .i_timestamp_us (s_axis_tdata[127:96]),
        .o_op_valid     (w_op_valid),
        .o_op           (w_op),
        .i_op_pop       (w_op_pop)
    );

    vcsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (w_op_valid),
        .i_op        (w_op),
        .o_op_pop    (w_op_pop),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (w_res)
    );

    // pack the status fields, lowest field first
    assign m_axis_tdata = {5'd0, w_res.odometer_um, w_res.steer_q8,
                           w_res.speed_eighths, w_res.turn_state, w_res.gear_state};

endmodule

`default_nettype wire

/* rtl/vcsd_front.sv */
// ----------------------------------------------------------------------------
// vcsd_front
// Accepts frames, classifies them by identifier and queues the work items.
// ----------------------------------------------------------------------------
`default_nettype none

module vcsd_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [31:0]     i_frame_id,
    input  wire logic [63:0]     i_frame_data,
    input  wire logic [31:0]     i_timestamp_us,
    output logic                 o_op_valid,
    output vcsd_pkg::t_op        o_op,
    input  wire logic            i_op_pop
);
    import vcsd_pkg::*;

    t_op        w_op;
    t_op        r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       w_push;

    // classify and pick the field that the back end needs
    always_comb begin
        w_op.ts = i_timestamp_us;
        unique case (i_frame_id)
            ID_GEAR: begin
                w_op.kind = OP_GEAR;
                w_op.arg  = {13'd0, i_frame_data[23:21]};
            end
            ID_SPEED: begin
                w_op.kind = OP_SPEED;
                w_op.arg  = {4'd0, i_frame_data[63:52]};
            end
            ID_STEER: begin
                w_op.kind = OP_STEER;
                w_op.arg  = i_frame_data[63:48];
            end
            ID_TURN: begin
                w_op.kind = OP_TURN;
                w_op.arg  = {14'd0, i_frame_data[37:36]};
            end
            default: begin
                w_op.kind = OP_OTHER;
                w_op.arg  = '0;
            end
        endcase
    end

    assign o_ready    = (r_count != 2'd2);
    assign w_push     = i_valid && o_ready;
    assign o_op_valid = (r_count != 2'd0);
    assign o_op       = r_mem[r_rptr];

    // two-entry queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= w_op;
        end
    end

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_op_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + {1'b0, w_push} - {1'b0, i_op_pop};
        end
    end

endmodule

`default_nettype wire

/* rtl/vcsd_div.sv */
// ----------------------------------------------------------------------------
// vcsd_div
// Divider by a small constant, one hex digit of quotient per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vcsd_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [5:0]                        i_divisor,
    input  wire logic [vcsd_pkg::DIV_NUM_W-1:0]    i_dividend,
    output logic                                   o_done,
    output logic [vcsd_pkg::DIV_NUM_W-1:0]         o_quot
);
    import vcsd_pkg::*;

    localparam int CNT_W = $clog2(DIV_DIGITS);

    logic [DIV_NUM_W-1:0] r_num;
    logic [5:0]           r_div;
    logic [5:0]           r_rem;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [9:0]           w_v;
    logic [9:0]           w_sub;
    logic [3:0]           w_digit;

    // one digit: count how many divisor multiples fit under the partial value
    always_comb begin
        w_v     = {r_rem, r_num[DIV_NUM_W-1 -: 4]};
        w_digit = 4'd0;
        w_sub   = 10'd0;
        for (int k = 1; k < 16; k++) begin
            if (w_v >= 10'(k) * {4'd0, r_div}) begin
                w_digit = 4'(k);
                w_sub   = 10'(k) * {4'd0, r_div};
            end
        end
    end

    // shift register holds dividend then quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_div <= i_divisor;
            r_rem <= 6'd0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_NUM_W-5:0], w_digit};
            r_rem <= 6'(w_v - w_sub);
        end
    end

    // digit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(DIV_DIGITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

`default_nettype wire

/* rtl/vcsd_back.sv */
// ----------------------------------------------------------------------------
// vcsd_back
// Executes queued items, holds the vehicle signals and the status register.
// ----------------------------------------------------------------------------
`default_nettype none

module vcsd_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_op_valid,
    input  wire vcsd_pkg::t_op   i_op,
    output logic                 o_op_pop,
    output logic                 o_res_valid,
    input  wire logic            i_res_ready,
    output vcsd_pkg::t_status    o_res
);
    import vcsd_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL1  = 3'd1;
    localparam logic [2:0] ST_MUL2  = 3'd2;
    localparam logic [2:0] ST_DIVGO = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_ACC   = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    t_op                   r_op;

    // architectural state
    logic [2:0]            r_gear_code;
    logic [1:0]            r_turn_code;
    logic [11:0]           r_speed_raw;
    logic signed [17:0]    r_steer;
    logic [31:0]           r_last_ts;
    logic [47:0]           r_odo;

    // datapath
    logic [17:0]           r_s19;
    logic [31:0]           r_dt;
    logic [49:0]           r_prod;
    logic [12:0]           w_sum;
    logic [48:0]           w_acc;
    logic [5:0]            w_divisor;
    logic [DIV_NUM_W-1:0]  w_dividend;
    logic                  w_div_start;
    logic                  w_div_done;
    logic [DIV_NUM_W-1:0]  w_quot;
    logic                  w_emit;

    t_status               r_res;
    logic                  r_res_valid;

    assign w_sum  = {1'b0, r_speed_raw} + {1'b0, r_op.arg[11:0]};
    assign w_acc  = {1'b0, r_odo} + {5'd0, w_quot};
    assign w_emit = (r_state == ST_EMIT) && (!r_res_valid || i_res_ready);

    assign o_op_pop    = (r_state == ST_IDLE) && i_op_valid;
    assign w_div_start = (r_state == ST_DIVGO);

    // dividend and divisor by item kind
    always_comb begin
        if (r_op.kind == OP_SPEED) begin
            w_divisor  = DIV_ODO;
            w_dividend = {1'b0, r_prod[49:ODO_SHR]};
        end else begin
            w_divisor  = DIV_STEER;
            w_dividend = {22'd0, r_op.arg, 6'd0};
        end
    end

    vcsd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_divisor  (w_divisor),
        .i_dividend (w_dividend),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_op_valid) begin
                    unique case (i_op.kind)
                        OP_SPEED: n_state = ST_MUL1;
                        OP_STEER: n_state = ST_DIVGO;
                        default:  n_state = ST_EMIT;
                    endcase
                end
            end
            ST_MUL1:  n_state = ST_MUL2;
            ST_MUL2:  n_state = ST_DIVGO;
            ST_DIVGO: n_state = ST_DIV;
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = (r_op.kind == OP_SPEED) ? ST_ACC : ST_EMIT;
                end
            end
            ST_ACC:   n_state = ST_EMIT;
            ST_EMIT: begin
                if (w_emit) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // latched item and multiplier stages
    always_ff @(posedge i_clk) begin
        if (o_op_pop) begin
            r_op <= i_op;
        end
        if (r_state == ST_MUL1) begin
            r_s19 <= {5'd0, w_sum} * ODO_GAIN;
            r_dt  <= r_op.ts - r_last_ts;
        end
        if (r_state == ST_MUL2) begin
            r_prod <= {32'd0, r_s19} * {18'd0, r_dt};
        end
    end

    // vehicle signal state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gear_code <= 3'd0;
            r_turn_code <= 2'd0;
            r_speed_raw <= 12'd0;
            r_steer     <= 18'sd0;
            r_last_ts   <= 32'd0;
            r_odo       <= 48'd0;
        end else begin
            if (o_op_pop && i_op.kind == OP_GEAR) begin
                r_gear_code <= i_op.arg[2:0];
            end
            if (o_op_pop && i_op.kind == OP_TURN) begin
                r_turn_code <= i_op.arg[1:0];
            end
            if (r_state == ST_DIV && w_div_done && r_op.kind == OP_STEER) begin
                r_steer <= $signed(w_quot[17:0] - STEER_OFFS);
            end
            // saturating odometer update
            if (r_state == ST_ACC) begin
                r_odo       <= (w_acc >= {1'b0, ODO_MAX}) ? ODO_MAX : w_acc[47:0];
                r_speed_raw <= r_op.arg[11:0];
                r_last_ts   <= r_op.ts;
            end
        end
    end

    // status output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_emit) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_res.gear_state    <= f_map_gear(r_gear_code);
            r_res.turn_state    <= r_turn_code;
            r_res.speed_eighths <= r_speed_raw;
            r_res.steer_q8      <= r_steer;
            r_res.odometer_um   <= r_odo;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

/* tb/vehicle_can_signal_decoder_test.sv */
// ----------------------------------------------------------------------------
// vehicle_can_signal_decoder_test
// Self-checking bench for the CAN signal decoder. Frames are sent as stream
// beats; a built-in status predictor tracks gear, turn, speed, steer and the
// trapezoid odometer, and every output beat is compared field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module vehicle_can_signal_decoder_test;

    import vcsd_pkg::*;

    localparam int          HALF_PERIOD  = 4;
    localparam int          LIMIT_CYCLES = 1_500_000;
    localparam int          TAIL_CYCLES  = 40;
    localparam int          DRAIN_CYCLES = 20_000;
    localparam longint      STEER_ZERO   = 9000;
    localparam logic [31:0] FLAG_EFF     = 32'h8000_0000;
    localparam logic [31:0] FLAG_RTR     = 32'h4000_0000;
    localparam logic [31:0] FLAG_ERR     = 32'h2000_0000;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // frame_id[31:0], frame_data[95:32], timestamp_us[127:96]
    logic [127:0] s_axis_tdata  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // gear_state[2:0], turn_state[4:3], speed_eighths[16:5],
    // steer_q8[34:17], odometer_um[82:35], zero fill [87:83]
    logic [87:0]  m_axis_tdata;

    // predicted vehicle state
    logic [2:0]         veh_gear_code;
    logic [1:0]         veh_turn_code;
    logic [11:0]        veh_speed_raw;
    logic signed [17:0] veh_steer_q8;
    logic [31:0]        veh_last_speed_ts;
    logic [47:0]        veh_odometer;

    t_status     pending_status[$];
    int          mismatch_count = 0;
    logic [31:0] ts_now         = '0;

    // idling controls for the sender and the ready process
    bit          tx_gaps_on   = 1'b1;
    bit          rx_stalls_on = 1'b1;
    int unsigned rx_hold_req  = 0;
    int unsigned rx_hold_left = 0;
    int unsigned rx_roll;

    vehicle_can_signal_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // run limit
    initial begin
        #(2 * HALF_PERIOD * LIMIT_CYCLES);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // status predictor
    // ------------------------------------------------------------------

    function automatic logic signed [17:0] steer_angle_q8(input logic [15:0] raw);
        longint num;
        longint q;
        num = (longint'(raw) - STEER_ZERO) * 256;
        // floor division, rounding toward minus infinity for negative angles
        if (num >= 0) begin
            q = num / 180;
        end else begin
            q = -((-num + 179) / 180);
        end
        return q[17:0];
    endfunction

    function automatic logic [2:0] gear_state_of(input logic [2:0] code);
        case (code)
            GCODE_PARK:    return GEAR_PARK;
            GCODE_NEUTRAL: return GEAR_NEUTRAL;
            GCODE_DRIVE:   return GEAR_DRIVE;
            GCODE_REVERSE: return GEAR_REVERSE;
            default:       return GEAR_FAIL;
        endcase
    endfunction

    // apply one frame to the predicted state and return the status it yields
    function automatic t_status update_vehicle_state(input logic [31:0] id,
                                                     input logic [63:0] data,
                                                     input logic [31:0] ts);
        t_status     st;
        logic [11:0] raw;
        logic [31:0] dt;
        logic [63:0] prod;
        logic [63:0] inc;
        if (id == ID_GEAR) begin
            veh_gear_code = data[23:21];
        end else if (id == ID_SPEED) begin
            raw  = data[63:52];
            dt   = ts - veh_last_speed_ts;
            prod = ({52'd0, veh_speed_raw} + {52'd0, raw}) * {32'd0, dt} * 64'd19;
            inc  = prod / 64'd1152;
            // saturating accumulate
            if (inc >= {16'd0, ODO_MAX} - {16'd0, veh_odometer}) begin
                veh_odometer = ODO_MAX;
            end else begin
                veh_odometer = veh_odometer + inc[47:0];
            end
            veh_speed_raw     = raw;
            veh_last_speed_ts = ts;
        end else if (id == ID_STEER) begin
            veh_steer_q8 = steer_angle_q8(data[63:48]);
        end else if (id == ID_TURN) begin
            veh_turn_code = data[37:36];
        end
        st.gear_state    = gear_state_of(veh_gear_code);
        st.turn_state    = veh_turn_code;
        st.speed_eighths = veh_speed_raw;
        st.steer_q8      = veh_steer_q8;
        st.odometer_um   = veh_odometer;
        return st;
    endfunction

    // ------------------------------------------------------------------
    // shared helpers
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("mismatch %0s: got 0x%0h expected 0x%0h", what, got, want);
    endtask

    function automatic int sender_gap();
        int unsigned roll;
        if (!tx_gaps_on) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 96) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // offer one frame beat and wait until it is taken; tvalid stays high
    task automatic send_frame(input logic [31:0] id, input logic [63:0] data,
                              input logic [31:0] ts);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ts, data, id};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_status.push_back(update_vehicle_state(id, data, ts));
    endtask

    // stop offering and wait until every expected status beat has come
    task automatic drain_results();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_status.size() != 0 && waited < DRAIN_CYCLES) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    // ------------------------------------------------------------------
    // receiver side: random stalls, long holds on request
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!rx_stalls_on) begin
            m_axis_tready <= 1'b1;
        end else begin
            rx_roll = $urandom_range(0, 199);
            if (rx_roll < 2) begin
                rx_hold_left = $urandom_range(10, 50);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= (rx_roll >= 50);
            end
        end
    end

    // status beat checker
    always @(posedge i_clk) begin
        t_status got;
        t_status want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_status'(m_axis_tdata[82:0]);
            if (pending_status.size() == 0) begin
                report_mismatch("unexpected status beat", m_axis_tdata[63:0], '0);
            end else begin
                want = pending_status.pop_front();
                if (got.gear_state !== want.gear_state)
                    report_mismatch("gear_state", 64'(got.gear_state),
                                    64'(want.gear_state));
                if (got.turn_state !== want.turn_state)
                    report_mismatch("turn_state", 64'(got.turn_state),
                                    64'(want.turn_state));
                if (got.speed_eighths !== want.speed_eighths)
                    report_mismatch("speed_eighths", 64'(got.speed_eighths),
                                    64'(want.speed_eighths));
                if (got.steer_q8 !== want.steer_q8)
                    report_mismatch("steer_q8", 64'(got.steer_q8), 64'(want.steer_q8));
                if (got.odometer_um !== want.odometer_um)
                    report_mismatch("odometer_um", 64'(got.odometer_um),
                                    64'(want.odometer_um));
                if (m_axis_tdata[87:83] !== 5'd0)
                    report_mismatch("zero fill", 64'(m_axis_tdata[87:83]), '0);
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // each field at its edges, the four mapped and two unmapped gear codes, every turn code, flagged identifiers
    task automatic test_directed();
        logic [63:0] data;
        logic [2:0]  gear_codes[6];
        logic [15:0] steer_raws[5];
        gear_codes = '{GCODE_PARK, GCODE_NEUTRAL, GCODE_DRIVE, GCODE_REVERSE,
                       3'd3, 3'd6};
        steer_raws = '{16'd0, 16'd9000, 16'hFFFF, 16'd8999, 16'd9001};
        // status straight after reset
        send_frame(32'h0, 64'h0, 32'h0);
        foreach (gear_codes[k]) begin
            data = {$urandom, $urandom};
            data[23:21] = gear_codes[k];
            send_frame(ID_GEAR, data, $urandom);
        end
        for (int k = 0; k < 4; k++) begin
            data = {$urandom, $urandom};
            data[37:36] = k[1:0];
            send_frame(ID_TURN, data, $urandom);
        end
        foreach (steer_raws[k]) begin
            data = {$urandom, $urandom};
            data[63:48] = steer_raws[k];
            send_frame(ID_STEER, data, $urandom);
        end
        // first speed frame measures from time zero, then zero speed,
        // a wrapped timestamp and one earlier than the last
        send_frame(ID_SPEED, {12'hFFF, 52'h0}, 32'd1000);
        send_frame(ID_SPEED, 64'h000F_FFFF_FFFF_FFFF, 32'hFFFF_FFF0);
        send_frame(ID_SPEED, {12'h800, 52'h0}, 32'h0000_0010);
        send_frame(ID_SPEED, {12'h123, 52'hF_FFFF_FFFF_FFFF}, 32'h0000_0008);
        // flag bits make an otherwise known identifier foreign
        send_frame(ID_SPEED | FLAG_EFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0100);
        send_frame(ID_GEAR | FLAG_RTR, 64'h0000_0000_00E0_0000, 32'h0000_0200);
        send_frame(ID_STEER | FLAG_ERR, 64'hFFFF_0000_0000_0000, 32'h0000_0300);
        send_frame(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        ts_now = 32'h0000_0400;
        drain_results();
    endtask

    // mostly decoded frames with random payloads, some foreign identifiers
    task automatic test_random_traffic(input int count);
        int unsigned roll;
        logic [31:0] id;
        logic [31:0] known_ids[4];
        known_ids = '{ID_GEAR, ID_SPEED, ID_STEER, ID_TURN};
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            id = known_ids[$urandom_range(0, 3)];
            if (roll >= 95) begin
                id = id + $urandom_range(1, 15);
            end else if (roll >= 85) begin
                id = $urandom;
            end else if (roll >= 75) begin
                id = id | ($urandom & (FLAG_EFF | FLAG_RTR | FLAG_ERR)) | FLAG_ERR;
            end
            // arrival time mostly moves forward a little
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
                ts_now = ts_now + $urandom_range(1, 5000);
            end else if (roll < 90) begin
                ts_now = ts_now + $urandom_range(0, 32'h000F_FFFF);
            end else if (roll < 95) begin
                ts_now = $urandom;
            end else begin
                ts_now = ts_now - $urandom_range(0, 1000);
            end
            send_frame(id, {$urandom, $urandom}, ts_now);
        end
        drain_results();
    endtask

    // receiver holds off while frames keep coming, so the input stalls
    task automatic test_back_pressure();
        logic [31:0] known_ids[4];
        known_ids = '{ID_GEAR, ID_SPEED, ID_STEER, ID_TURN};
        tx_gaps_on  = 1'b0;
        rx_hold_req = 300;
        for (int n = 0; n < 30; n++) begin
            ts_now = ts_now + $urandom_range(1, 2000);
            send_frame(known_ids[$urandom_range(0, 3)], {$urandom, $urandom}, ts_now);
        end
        drain_results();
        tx_gaps_on = 1'b1;
    endtask

    // full rate on both sides
    task automatic test_steady_stream(input int count);
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        test_random_traffic(count);
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    // top speed with the largest time step until the odometer pins at maximum
    task automatic test_odometer_saturation();
        int n;
        n = 0;
        tx_gaps_on = 1'b0;
        while (veh_odometer != ODO_MAX && n < 700) begin
            ts_now = ts_now - 32'd1;
            send_frame(ID_SPEED, {12'hFFF, 20'h0, $urandom}, ts_now);
            n++;
        end
        // held at maximum afterwards
        for (int k = 0; k < 4; k++) begin
            ts_now = ts_now - 32'd1;
            send_frame(ID_SPEED, {12'hFFF, 20'h0, $urandom}, ts_now);
        end
        drain_results();
        tx_gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        veh_gear_code     = GCODE_PARK;
        veh_turn_code     = '0;
        veh_speed_raw     = '0;
        veh_steer_q8      = '0;
        veh_last_speed_ts = '0;
        veh_odometer      = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_traffic(500);
        test_back_pressure();
        test_steady_stream(150);
        test_random_traffic(200);
        test_odometer_saturation();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_status.size() != 0) begin
            report_mismatch("status beats never delivered",
                            64'(pending_status.size()), '0);
        end
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
